FILE: rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared constants, types and witness table for the primality tester
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int MaxWordBits     = 64;
  localparam int MaxWitnessCount = 13;
  localparam int CandBits        = 64;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;  // load n, d = n-1
  localparam logic [2:0] OP_SPLIT = 3'd2;  // d >>= 1, s++
  localparam logic [2:0] OP_WIT   = 3'd3;  // base = a, acc = 1, e = d
  localparam logic [2:0] OP_MULA  = 3'd4;  // acc = acc*base
  localparam logic [2:0] OP_SQB   = 3'd5;  // base = base*base, e >>= 1
  localparam logic [2:0] OP_SQA   = 3'd6;  // acc = acc*acc, round++

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] widx;
  } mrpt_cmd_t;

  typedef struct packed {
    logic done;        // multiply finished
    logic busy;
    logic n_small;     // n < 2
    logic n_tiny;      // n == 2 or 3
    logic n_even;
    logic d_even;
    logic wit_ge_n;
    logic e_zero;
    logic e_odd;
    logic acc_one;
    logic acc_nm1;
    logic round_last;  // round >= s
  } mrpt_sts_t;

  function automatic logic [5:0] witness_of(input logic [3:0] i);
    case (i)
      4'd0:  witness_of = 6'd2;
      4'd1:  witness_of = 6'd3;
      4'd2:  witness_of = 6'd5;
      4'd3:  witness_of = 6'd7;
      4'd4:  witness_of = 6'd11;
      4'd5:  witness_of = 6'd13;
      4'd6:  witness_of = 6'd17;
      4'd7:  witness_of = 6'd19;
      4'd8:  witness_of = 6'd23;
      4'd9:  witness_of = 6'd29;
      4'd10: witness_of = 6'd31;
      4'd11: witness_of = 6'd37;
      4'd12: witness_of = 6'd41;
      default: witness_of = 6'd41;
    endcase
  endfunction

endpackage

FILE: rtl/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// mrpt_datapath
// working registers and a shift-add modular multiplier, one bit a cycle
// ----------------------------------------------------------------------------
module mrpt_datapath #(
  parameter int WORD_BITS = mrpt_pkg::MaxWordBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WORD_BITS-1:0] cand,
  input  mrpt_pkg::mrpt_cmd_t  cmd,
  output mrpt_pkg::mrpt_sts_t  sts
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(WORD_BITS);
  localparam int SW = CW + 1;

  logic [WORD_BITS-1:0] n_r, d_r, acc_r, base_r, e_r;
  logic [SW-1:0]        s_r, round_r;

  // multiplier
  logic                 mbusy_r, mdone_r, mdst_r;  // mdst: 0 acc, 1 base
  logic [WORD_BITS-1:0] mx_r, my_r, macc_r;
  logic [CW-1:0]        mbit_r;

  logic [WORD_BITS-1:0] dbl, addv, wit_w;
  logic [WORD_BITS:0]   sum1, sum2;

  assign wit_w = WORD_BITS'(witness_of(cmd.widx));

  always_comb begin
    sum1 = {1'b0, macc_r} + {1'b0, macc_r};
    dbl  = (sum1 >= {1'b0, n_r}) ? WORD_BITS'(sum1 - {1'b0, n_r}) : macc_r + macc_r;
    sum2 = {1'b0, dbl} + {1'b0, mx_r};
    if (my_r[mbit_r])
      addv = (sum2 >= {1'b0, n_r}) ? WORD_BITS'(sum2 - {1'b0, n_r}) : WORD_BITS'(sum2);
    else
      addv = dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
    end else begin
      if (mbusy_r) begin
        macc_r <= addv;
        if (mbit_r == '0) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
          if (mdst_r) base_r <= addv;
          else        acc_r  <= addv;
        end else begin
          mdone_r <= 1'b0;
        end
        mbit_r <= mbit_r - 1'b1;
      end else begin
        mdone_r <= 1'b0;
        case (cmd.op)
          OP_LOAD: begin
            n_r <= cand;
            d_r <= cand - 1'b1;
            s_r <= '0;
          end
          OP_SPLIT: begin
            d_r <= d_r >> 1;
            s_r <= s_r + 1'b1;
          end
          OP_WIT: begin
            base_r  <= wit_w;
            acc_r   <= WORD_BITS'(1);
            e_r     <= d_r;
            round_r <= SW'(1);
          end
          OP_MULA: begin
            mx_r <= acc_r; my_r <= base_r; mdst_r <= 1'b0;
            macc_r <= '0; mbit_r <= CW'(WORD_BITS - 1); mbusy_r <= 1'b1;
          end
          OP_SQB: begin
            mx_r <= base_r; my_r <= base_r; mdst_r <= 1'b1;
            macc_r <= '0; mbit_r <= CW'(WORD_BITS - 1); mbusy_r <= 1'b1;
            e_r <= e_r >> 1;
          end
          OP_SQA: begin
            mx_r <= acc_r; my_r <= acc_r; mdst_r <= 1'b0;
            macc_r <= '0; mbit_r <= CW'(WORD_BITS - 1); mbusy_r <= 1'b1;
            round_r <= round_r + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts.done       = mdone_r;
    sts.busy       = mbusy_r;
    sts.n_small    = (cand < WORD_BITS'(2));
    sts.n_tiny     = (cand == WORD_BITS'(2)) || (cand == WORD_BITS'(3));
    sts.n_even     = ~cand[0];
    sts.d_even     = ~d_r[0];
    sts.wit_ge_n   = (wit_w >= n_r);
    sts.e_zero     = (e_r == '0);
    sts.e_odd      = e_r[0];
    sts.acc_one    = (acc_r == WORD_BITS'(1));
    sts.acc_nm1    = (acc_r == n_r - 1'b1);
    sts.round_last = (round_r >= s_r);
  end

  assert property (@(posedge clk) disable iff (!rst_n) mdone_r |-> !mbusy_r)
    else $error("multiplier done while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (mbusy_r && mbit_r == '0) |=> mdone_r)
    else $error("multiplier did not finish");
  assert property (@(posedge clk) disable iff (!rst_n) mbusy_r |-> macc_r < n_r)
    else $error("partial product out of range");

endmodule

FILE: rtl/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mrpt_ctrl
// sequencer over split, witnesses, exponentiation and squaring rounds
// ----------------------------------------------------------------------------
module mrpt_ctrl #(
  parameter int WITNESS_COUNT = mrpt_pkg::MaxWitnessCount
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_prime_flag,
  input  mrpt_pkg::mrpt_sts_t sts,
  output mrpt_pkg::mrpt_cmd_t cmd
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPLIT = 4'd1;
  localparam logic [3:0] S_WIT   = 4'd2;
  localparam logic [3:0] S_CHKW  = 4'd3;
  localparam logic [3:0] S_EXP   = 4'd4;
  localparam logic [3:0] S_WMUL  = 4'd5;
  localparam logic [3:0] S_SQB   = 4'd6;
  localparam logic [3:0] S_WSQB  = 4'd7;
  localparam logic [3:0] S_TEST  = 4'd8;
  localparam logic [3:0] S_SQA   = 4'd9;
  localparam logic [3:0] S_WSQA  = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic [3:0] w_r, w_nxt;
  logic       res_r, res_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall       = (st_r != S_IDLE) || ov_r;
  assign out_valid      = ov_r;
  assign out_prime_flag = res_r;

  always_comb begin
    st_nxt = st_r; w_nxt = w_r; res_nxt = res_r; ov_nxt = ov_r;
    cmd.op = OP_NONE; cmd.widx = w_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid && !ov_r) begin
        if (sts.n_small || sts.n_even || sts.n_tiny) begin
          res_nxt = sts.n_tiny;
          ov_nxt  = 1'b1;
        end else begin
          cmd.op = OP_LOAD;
          st_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (sts.d_even) cmd.op = OP_SPLIT;
        else begin
          w_nxt  = '0;
          st_nxt = S_CHKW;
        end
      end
      S_CHKW: begin
        if (sts.wit_ge_n) st_nxt = S_NEXT;
        else begin
          cmd.op = OP_WIT;
          st_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (sts.e_zero) st_nxt = S_TEST;
        else if (sts.e_odd) begin
          cmd.op = OP_MULA;
          st_nxt = S_WMUL;
        end else st_nxt = S_SQB;
      end
      S_WMUL: if (sts.done) st_nxt = S_SQB;
      S_SQB: begin
        cmd.op = OP_SQB;
        st_nxt = S_WSQB;
      end
      S_WSQB: if (sts.done) st_nxt = S_EXP;
      S_TEST: begin
        if (sts.acc_one || sts.acc_nm1) st_nxt = S_NEXT;
        else st_nxt = S_SQA;
      end
      S_SQA: begin
        if (sts.round_last) begin
          res_nxt = 1'b0;
          st_nxt  = S_OUT;
        end else begin
          cmd.op = OP_SQA;
          st_nxt = S_WSQA;
        end
      end
      S_WSQA: if (sts.done) st_nxt = sts.acc_nm1 ? S_NEXT : S_SQA;
      S_NEXT: begin
        if (w_r == 4'(WITNESS_COUNT - 1)) begin
          res_nxt = 1'b1;
          st_nxt  = S_OUT;
        end else begin
          w_nxt  = w_r + 1'b1;
          st_nxt = S_CHKW;
        end
      end
      S_OUT: if (!ov_r) begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // S_WIT kept unused as a spare code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; w_r <= '0; res_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= (st_nxt == S_WIT) ? S_IDLE : st_nxt;
      w_r <= w_nxt; res_r <= res_nxt; ov_r <= ov_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (st_r != S_IDLE) |-> in_stall)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WMUL || st_r == S_WSQB || st_r == S_WSQA) |-> (sts.busy || sts.done))
    else $error("waiting on idle multiplier");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && st_r != S_SPLIT) |-> w_r < 4'(WITNESS_COUNT))
    else $error("witness index out of range");

endmodule

FILE: rtl/miller_rabin_prime_test.sv
// small, tiny or even candidates are answered without the multiplier; odd ones take
// about witnesses * (2 * log2(n)) modular products on the bit-serial multiplier
// throughput: one item at a time; next item taken once the result is taken
// reset: rst_n synchronous active low clears the sequencer and output valid
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// deterministic miller-rabin primality test of one word
// ----------------------------------------------------------------------------
module miller_rabin_prime_test #(
  parameter int WORD_BITS     = mrpt_pkg::MaxWordBits,
  parameter int WITNESS_COUNT = mrpt_pkg::MaxWitnessCount
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mrpt_pkg::CandBits-1:0] in_candidate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_prime_flag
);
  import mrpt_pkg::*;

  mrpt_cmd_t cmd;
  mrpt_sts_t sts;

  mrpt_ctrl #(.WITNESS_COUNT(WITNESS_COUNT)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_prime_flag, .sts, .cmd
  );

  mrpt_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst_n, .cand(in_candidate[WORD_BITS-1:0]), .cmd, .sts
  );

endmodule
